FILE: rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Types, constants and opcodes shared by the pressure/temperature compensation.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int unsigned CalWideW   = 48;
  localparam int unsigned CalNarrowW = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned RawW       = 24;
  localparam int unsigned WordW      = 32;

  localparam logic [CfgIdxW-1:0] REG_A  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_B  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_C  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_D  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OS = 3'd4;

  localparam logic [WordW-1:0] K_B6_OFS = 32'd4000;
  localparam logic [WordW-1:0] K_P1     = 32'd3038;
  localparam logic [WordW-1:0] K_P2     = 32'hFFFF_E343;  // -7357
  localparam logic [WordW-1:0] K_P3     = 32'd3791;
  localparam logic [WordW-1:0] K_B7     = 32'd50000;
  localparam logic [WordW-1:0] K_SIGN   = 32'h8000_0000;
  localparam logic [WordW-1:0] K_HALF   = 32'd32768;

  // Datapath step codes. Each step is one register-to-register operation.
  typedef enum logic [5:0] {
    OP_NOP,
    OP_T_SUB,     // t = ut - ac6
    OP_T_MUL,     // x1 = asr(t*ac5,15)
    OP_T_DEN,     // den = x1 + md ; z flag
    OP_T_DIVST,   // start div (mc<<11)/den signed
    OP_T_B5,      // b5 = x1 + q
    OP_T_OUT,     // value = asr(b5+8,4)
    OP_P_B6,      // b6 = b5 - 4000
    OP_P_SQ,      // sq = asr(b6*b6,12)
    OP_P_X1,      // x1 = asr(b2*sq,11)
    OP_P_X2,      // x2 = asr(ac2*b6,11)
    OP_P_B3,      // b3 = sdiv(((ac1*4+x1+x2)<<oss)+2,4)
    OP_P_Y1,      // x1 = asr(ac3*b6,13)
    OP_P_Y2,      // x2 = asr(b1*sq,16)
    OP_P_Y3,      // x3 = asr(x1+x2+2,2)+32768
    OP_P_B4,      // b4 = (ac4*x3)>>15 ; z flag
    OP_P_B7,      // b7 = (up-b3)*(50000>>oss)
    OP_P_DIVST,   // start unsigned div
    OP_P_P,       // p from quotient
    OP_P_Q1,      // x1 = asr(p,8)
    OP_P_Q2,      // x1 = x1*x1
    OP_P_Q3,      // x1 = asr(x1*3038,16)
    OP_P_Q4,      // x2 = asr(-7357*p,16)
    OP_P_OUT,     // value = p + asr(x1+x2+3791,4)
    OP_ZERO,      // value = 0, err = 0
    OP_ERR        // value = 0, err = 1
  } op_t;

  typedef struct packed {
    logic load;     // capture input item
    op_t  op;
  } brc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic zero;     // last divisor check was zero
    logic up_zero;  // shifted raw pressure is zero
    logic kind;     // captured action
  } brc_sts_t;

  function automatic logic [WordW-1:0] asr32(input logic [WordW-1:0] v,
                                               input int unsigned n);
    asr32 = WordW'($signed(v) >>> n);
  endfunction

  function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction

endpackage

FILE: rtl/brc_div.sv
// ----------------------------------------------------------------------------
// brc_div
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  import brc_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial    = {rem, quo[31]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/brc_datapath.sv
// ----------------------------------------------------------------------------
// brc_datapath
// Configuration registers, working registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module brc_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic [brc_pkg::CfgIdxW-1:0] register_index,
  input  logic [brc_pkg::CalWideW-1:0] write_data,
  input  logic                     action,
  input  logic [brc_pkg::RawW-1:0] raw_reading,
  input  brc_pkg::brc_cmd_t        cmd,
  output brc_pkg::brc_sts_t        sts,
  output logic [31:0]              value,
  output logic                     err
);
  import brc_pkg::*;

  logic [47:0] reg_a, reg_b, reg_d;
  logic [31:0] reg_c;
  logic [1:0]  reg_os;
  logic [15:0] ut;
  logic        kind;
  logic        zero;
  logic [31:0] t, x1, x2, b5, b6, sq, b3, b4, p, up, q;
  logic        neg_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
  assign ac1 = sx16(reg_a[47:32]);
  assign ac2 = sx16(reg_a[31:16]);
  assign ac3 = sx16(reg_a[15:0]);
  assign ac4 = {16'd0, reg_b[47:32]};
  assign ac5 = {16'd0, reg_b[31:16]};
  assign ac6 = {16'd0, reg_b[15:0]};
  assign cb1 = sx16(reg_c[31:16]);
  assign cb2 = sx16(reg_c[15:0]);
  assign mc  = sx16(reg_d[31:16]);
  assign md  = sx16(reg_d[15:0]);

  // shared 32x32 multiplier, low word only
  logic [31:0] ma, mb, prod;
  assign prod = ma * mb;

  always_comb begin
    ma = t;
    mb = ac5;
    case (cmd.op)
      OP_P_SQ:  begin ma = b6;  mb = b6;    end
      OP_P_X1:  begin ma = cb2; mb = sq;    end
      OP_P_X2:  begin ma = ac2; mb = b6;    end
      OP_P_Y1:  begin ma = ac3; mb = b6;    end
      OP_P_Y2:  begin ma = cb1; mb = sq;    end
      OP_P_B4:  begin ma = ac4; mb = x2;    end
      OP_P_B7:  begin ma = up - b3; mb = K_B7 >> reg_os; end
      OP_P_Q2:  begin ma = x1;  mb = x1;    end
      OP_P_Q3:  begin ma = x1;  mb = K_P1;  end
      OP_P_Q4:  begin ma = K_P2; mb = p;    end
      default:  begin ma = t;   mb = ac5;   end
    endcase
  end

  // divider: signed handled by magnitudes
  logic        div_start, div_busy;
  logic [31:0] dvd, dvs, dquo, mcs, mag_n, mag_d;
  assign mcs   = mc << 11;
  assign mag_n = mcs[31] ? (32'd0 - mcs) : mcs;
  assign mag_d = x2[31] ? (32'd0 - x2) : x2;
  always_comb begin
    div_start = 1'b0;
    dvd = mag_n;
    dvs = mag_d;
    case (cmd.op)
      OP_T_DIVST: div_start = 1'b1;
      OP_P_DIVST: begin
        div_start = 1'b1;
        dvd = q[31] ? q : {q[30:0], 1'b0};
        dvs = b4;
      end
      default: ;
    endcase
  end

  brc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quotient (dquo)
  );

  logic [31:0] b3pre, x3;
  assign b3pre = (((ac1 << 2) + x1 + x2) << reg_os) + 32'd2;
  assign x3    = asr32(x1 + x2 + 32'd2, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a  <= '0;
      reg_b  <= '0;
      reg_c  <= '0;
      reg_d  <= '0;
      reg_os <= '0;
      ut     <= '0;
    end else begin
      if (write_enable) begin
        unique case (register_index)
          REG_A:  reg_a  <= write_data;
          REG_B:  reg_b  <= write_data;
          REG_C:  reg_c  <= write_data[31:0];
          REG_D:  reg_d  <= write_data;
          REG_OS: reg_os <= write_data[1:0];
          default: ;
        endcase
      end
      if (cmd.load && !action) begin
        ut <= raw_reading[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= action;
      up   <= {8'd0, raw_reading} >> (4'd8 - {2'd0, reg_os});
    end
    case (cmd.op)
      OP_T_SUB:   t  <= {16'd0, ut} - ac6;
      OP_T_MUL:   x1 <= asr32(prod, 15);
      OP_T_DEN:   begin x2 <= x1 + md; zero <= (x1 + md) == 32'd0; end
      OP_T_DIVST: neg_q <= mcs[31] ^ x2[31];
      OP_T_B5:    b5 <= x1 + (neg_q ? (32'd0 - dquo) : dquo);
      OP_T_OUT:   begin value <= asr32(b5 + 32'd8, 4); err <= 1'b0; end
      OP_P_B6:    b6 <= b5 - K_B6_OFS;
      OP_P_SQ:    sq <= asr32(prod, 12);
      OP_P_X1:    x1 <= asr32(prod, 11);
      OP_P_X2:    x2 <= asr32(prod, 11);
      OP_P_B3:    b3 <= asr32(b3pre, 2) + {31'd0, b3pre[31] & (b3pre[1:0] != 2'd0)};
      OP_P_Y1:    x1 <= asr32(prod, 13);
      OP_P_Y2:    x2 <= asr32(prod, 16);
      OP_P_Y3:    x2 <= x3 + K_HALF;
      OP_P_B4:    begin b4 <= prod >> 15; zero <= (prod >> 15) == 32'd0; end
      OP_P_B7:    q <= prod;
      OP_P_P:     p <= q[31] ? {dquo[30:0], 1'b0} : dquo;
      OP_P_Q1:    x1 <= asr32(p, 8);
      OP_P_Q2:    x1 <= prod;
      OP_P_Q3:    x1 <= asr32(prod, 16);
      OP_P_Q4:    x2 <= asr32(prod, 16);
      OP_P_OUT:   begin value <= p + asr32(x1 + x2 + K_P3, 4); err <= 1'b0; end
      OP_ZERO:    begin value <= '0; err <= 1'b0; end
      OP_ERR:     begin value <= '0; err <= 1'b1; end
      default: ;
    endcase
  end

  assign sts.div_busy = div_busy;
  assign sts.zero     = zero;
  assign sts.up_zero  = (up == 32'd0);
  assign sts.kind     = kind;
endmodule

FILE: rtl/brc_ctrl.sv
// ----------------------------------------------------------------------------
// brc_ctrl
// Sequencer: walks the datapath through the compensation steps of one request.
// ----------------------------------------------------------------------------
module brc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  brc_pkg::brc_sts_t sts,
  output brc_pkg::brc_cmd_t cmd
);
  import brc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.load   = 1'b0;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
          op_next    = OP_T_SUB;
        end
      end
      S_RUN: begin
        cmd.op  = op;
        op_next = op_t'(op + 6'd1);
        case (op)
          OP_T_SUB: if (sts.kind && sts.up_zero) begin
            cmd.op = OP_ZERO; state_next = S_OUT;
          end
          OP_T_DIVST, OP_P_DIVST: state_next = S_DIV;
          OP_T_DEN: ;
          OP_T_B5: if (sts.kind) op_next = OP_P_B6;
          OP_T_OUT, OP_P_OUT, OP_ZERO, OP_ERR: state_next = S_OUT;
          default: ;
        endcase
        // divisor checks use the zero flag registered by the den or b4 step
        if ((op == OP_T_DIVST || op == OP_P_DIVST) && sts.zero) begin
          cmd.op = OP_ERR; state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) state_next = S_RUN;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NOP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end
endmodule

FILE: rtl/barometer_reading_compensation.sv
// ----------------------------------------------------------------------------
// barometer_reading_compensation
// Integer datasheet compensation of raw barometer temperature and pressure.
// ----------------------------------------------------------------------------
// One request at a time. A temperature request uses the serial divider once and
// a pressure request twice, with the shared multiplier stepped by the sequencer;
// a zero raw pressure skips the steps and gives a zero result. The result
// register holds until taken.
module barometer_reading_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [2:0]  register_index,
  input  logic [47:0] write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [23:0] raw_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        measurement_kind,
  output logic signed [31:0] measured_value,
  output logic        divide_error
);
  import brc_pkg::*;

  brc_cmd_t    cmd;
  brc_sts_t    sts;
  logic [31:0] value;

  brc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts(sts), .cmd(cmd)
  );

  brc_datapath u_dp (
    .clk, .rst, .write_enable, .register_index, .write_data,
    .action, .raw_reading, .cmd(cmd), .sts(sts), .value(value),
    .err(divide_error)
  );

  assign measurement_kind = sts.kind;
  assign measured_value   = $signed(value);
endmodule

FILE: rtl/brc_checker.sv
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks of the compensation block.
// ----------------------------------------------------------------------------
module brc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        action,
  input logic        measurement_kind,
  input logic [31:0] measured_value,
  input logic        divide_error
);
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepting while result pending");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##2 (measurement_kind == $past(action, 3)))
    else $error("kind mismatch");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_error) |-> measured_value == 32'd0)
    else $error("error with nonzero value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(measured_value))
    else $error("result dropped");
endmodule

bind barometer_reading_compensation brc_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .action,
  .measurement_kind, .measured_value, .divide_error
);
